@@ src/sdtq_pkg.sv @@
// Shared types and constants for the sorted deadline timer queue.
package sdtq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_RESULTS    = 16;

    // 1e9 = 2^9 * 5^9
    localparam logic [20:0] DIV_5P9         = 21'd1953125;
    // floor(2^52 / 5^9)
    localparam logic [31:0] RECIP_5P9       = 32'd2305843009;
    localparam logic [31:0] CPU_HZ_RESET    = 32'd10000000;
    localparam logic [31:0] TICKS_HZ_RESET  = 32'd100000;

    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_DEL  = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic REG_CPU_HZ   = 1'b0;
    localparam logic REG_TICKS_HZ = 1'b1;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  timer_id;
        logic [39:0] interval_ns;
        logic        periodic;
        logic [63:0] now;
    } t_in_item;

    typedef struct packed {
        logic        fired;
        logic [3:0]  fired_id;
        logic        last;
        logic        compare_write;
        logic [63:0] compare_value;
        logic [63:0] next_deadline;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [39:0] ns;
        logic [31:0] hz;
    } t_tk_req;

    typedef struct packed {
        logic        done;
        logic [63:0] ticks;
    } t_tk_rsp;

endpackage

@@ src/sdtq_ram.sv @@
// Single write port, single read port RAM with registered read data.
module sdtq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/sdtq_tick_conv.sv @@
// Converts nanoseconds to ticks: floor(ns * hz / 1e9), multiply then reciprocal division.
module sdtq_tick_conv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sdtq_pkg::t_tk_req i_req,
    output sdtq_pkg::t_tk_rsp o_rsp
);
    // x / 1e9 = (x >> 9) / 5^9; the shifted product is divided in three 21-bit digits,
    // each estimated by a reciprocal multiply and fixed by one compare and subtract
    typedef enum logic [4:0] {
        TC_IDLE = 5'b00001,
        TC_SUM  = 5'b00010,
        TC_MUL  = 5'b00100,
        TC_EST  = 5'b01000,
        TC_FIX  = 5'b10000
    } t_tc_state;

    t_tc_state   r_state, n_state;
    logic [63:0] r_plo;
    logic [39:0] r_phi;
    logic [62:0] r_x;
    logic [20:0] r_rem;
    logic [41:0] r_n;
    logic [63:0] r_m;
    logic [20:0] r_qe;
    logic [41:0] r_qd;
    logic [62:0] r_quo;
    logic [1:0]  r_cnt;
    logic        r_done, n_done;
    logic [71:0] prod;
    logic [41:0] num;
    logic [41:0] diff;
    logic        ge;

    assign prod = {r_phi, 32'd0} + {8'd0, r_plo};
    assign num  = {r_rem, r_x[62:42]};
    // estimate is low by at most one
    assign diff = r_n - r_qd;
    assign ge   = diff >= {21'd0, sdtq_pkg::DIV_5P9};

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            TC_IDLE: if (i_req.start) n_state = TC_SUM;
            TC_SUM:  n_state = TC_MUL;
            TC_MUL:  n_state = TC_EST;
            TC_EST:  n_state = TC_FIX;
            TC_FIX: begin
                if (r_cnt == 2'd2) begin
                    n_state = TC_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_state = TC_MUL;
                end
            end
            default: n_state = TC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TC_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        case (r_state)
            TC_IDLE: begin
                r_plo <= i_req.ns[31:0] * i_req.hz;
                r_phi <= i_req.ns[39:32] * i_req.hz;
            end
            TC_SUM: begin
                r_x   <= prod[71:9];
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= '0;
            end
            TC_MUL: begin
                r_n <= num;
                r_m <= num[41:10] * sdtq_pkg::RECIP_5P9;
                r_x <= {r_x[41:0], 21'd0};
            end
            TC_EST: begin
                r_qe <= r_m[62:42];
                r_qd <= r_m[62:42] * sdtq_pkg::DIV_5P9;
            end
            TC_FIX: begin
                if (ge) begin
                    r_quo <= {r_quo[41:0], r_qe + 21'd1};
                    r_rem <= 21'(diff - {21'd0, sdtq_pkg::DIV_5P9});
                end else begin
                    r_quo <= {r_quo[41:0], r_qe};
                    r_rem <= diff[20:0];
                end
                r_cnt <= r_cnt + 2'd1;
            end
            default: ;
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.ticks = {1'b0, r_quo};
endmodule

@@ src/sorted_deadline_timer_queue_top.sv @@
// Top level of the sorted deadline timer queue: sequencer over slot and order memories.
// One item at a time; busy falls in the same cycle that its last result is driven. The order
// list is walked through memories with registered read data for each unlink, search and
// shift, and each interval conversion waits on the divider until it signals done. Results
// appear for one cycle on o_result with o_result_valid and cannot be held off.
module sorted_deadline_timer_queue_top #(
    parameter int NUM_TIMERS = sdtq_pkg::NUM_TIMERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sdtq_pkg::t_in_item  i_item,
    output logic                o_result_valid,
    output sdtq_pkg::t_out_item o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int IW = $clog2(NUM_TIMERS);
    localparam int CW = $clog2(NUM_TIMERS + 1);

    typedef enum logic [20:0] {
        S_IDLE    = 21'h000001,
        S_ADD_RD  = 21'h000002,
        S_CV_WAIT = 21'h000004,
        S_DL_SET  = 21'h000008,
        S_UL_RD   = 21'h000010,
        S_UL_CMP  = 21'h000020,
        S_SD_RD   = 21'h000040,
        S_SD_WR   = 21'h000080,
        S_LK_RD   = 21'h000100,
        S_LK_RD2  = 21'h000200,
        S_LK_CMP  = 21'h000400,
        S_LI_RD   = 21'h000800,
        S_LI_WR   = 21'h001000,
        S_CL1     = 21'h002000,
        S_CL2     = 21'h004000,
        S_HD_RD   = 21'h008000,
        S_HD_RD2  = 21'h010000,
        S_HD_CMP  = 21'h020000,
        S_DEC     = 21'h040000,
        S_TP_RD   = 21'h080000,
        S_TP_GO   = 21'h100000
    } t_state;

    t_state r_state, n_state;

    logic [31:0] r_cpu_hz, r_tph;
    logic [1:0]  r_func, n_func;
    logic [39:0] r_ns, n_ns;
    logic        r_per, n_per;
    logic [63:0] r_now, n_now;
    logic [IW-1:0] r_t, n_t, r_hslot, n_hslot, r_dslot;
    logic [CW-1:0] r_p, n_p, r_q, n_q, r_count, n_count;
    logic [NUM_TIMERS-1:0] r_queued, n_queued, r_isper, n_isper, r_dlval, n_dlval;
    logic        r_dlv_q;
    logic [63:0] r_d, n_d, r_hz, n_hz, r_head, n_head, r_cv, n_cv;
    logic        r_cw, n_cw, r_exp, n_exp, r_pend, n_pend;
    logic [4:0]  r_k, n_k;
    logic        r_ov, n_ov;
    sdtq_pkg::t_out_item r_out, n_out;

    logic          ord_we, ord_re, dl_we, dl_re, per_we, per_re;
    logic [IW-1:0] ord_wa, ord_ra, dl_wa, dl_ra, per_wa, per_ra;
    logic [IW-1:0] ord_wd, ord_rd;
    logic [63:0]   dl_wd, dl_rd, dl_eff;
    logic [39:0]   per_wd, per_rd;

    sdtq_pkg::t_tk_req tk_req;
    sdtq_pkg::t_tk_rsp tk_rsp;

    logic        accept, id_ok;
    logic [39:0] ns_fix;
    logic [63:0] base;

    sdtq_ram #(.WIDTH(IW), .DEPTH(NUM_TIMERS)) u_ord (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_wa), .i_wdata(ord_wd),
        .i_re(ord_re), .i_raddr(ord_ra), .o_rdata(ord_rd)
    );
    sdtq_ram #(.WIDTH(64), .DEPTH(NUM_TIMERS)) u_dl (
        .i_clk(i_clk), .i_we(dl_we), .i_waddr(dl_wa), .i_wdata(dl_wd),
        .i_re(dl_re), .i_raddr(dl_ra), .o_rdata(dl_rd)
    );
    sdtq_ram #(.WIDTH(40), .DEPTH(NUM_TIMERS)) u_per (
        .i_clk(i_clk), .i_we(per_we), .i_waddr(per_wa), .i_wdata(per_wd),
        .i_re(per_re), .i_raddr(per_ra), .o_rdata(per_rd)
    );
    sdtq_tick_conv u_conv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(tk_req), .o_rsp(tk_rsp)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign id_ok  = (IW + 4)'(i_item.timer_id) < (IW + 4)'(NUM_TIMERS);
    assign ns_fix = (r_ns == '0) ? 40'd1 : r_ns;
    // never-written deadlines read as zero
    assign dl_eff = r_dlv_q ? dl_rd : 64'd0;
    assign base   = (r_func == sdtq_pkg::FUNC_ADD && (!r_per || dl_eff == 64'd0)) ?
                    r_now : dl_eff;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sdtq_pkg::REG_TICKS_HZ) ? r_tph : r_cpu_hz;

    always_comb begin
        n_state = r_state;
        n_func = r_func; n_ns = r_ns; n_per = r_per; n_now = r_now;
        n_t = r_t; n_hslot = r_hslot; n_p = r_p; n_q = r_q; n_count = r_count;
        n_queued = r_queued; n_isper = r_isper; n_dlval = r_dlval;
        n_d = r_d; n_hz = r_hz; n_head = r_head; n_cv = r_cv; n_cw = r_cw;
        n_exp = r_exp; n_pend = r_pend; n_k = r_k;
        n_ov = 1'b0; n_out = r_out;
        ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_re = 1'b0; ord_ra = '0;
        dl_we = 1'b0; dl_wa = r_t; dl_wd = r_d; dl_re = 1'b0; dl_ra = r_t;
        per_we = 1'b0; per_wa = r_t; per_wd = ns_fix; per_re = 1'b0; per_ra = r_t;
        tk_req.start = 1'b0; tk_req.ns = ns_fix; tk_req.hz = r_cpu_hz;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func = i_item.func; n_ns = i_item.interval_ns;
                    n_per = i_item.periodic; n_now = i_item.now;
                    n_t = IW'(i_item.timer_id);
                    n_p = '0; n_cw = 1'b0; n_cv = '0; n_k = '0; n_pend = 1'b0;
                    n_state = S_HD_RD;
                    case (i_item.func)
                        sdtq_pkg::FUNC_ADD: begin
                            if (id_ok) begin
                                n_state = r_queued[IW'(i_item.timer_id)] ? S_UL_RD : S_ADD_RD;
                            end
                        end
                        sdtq_pkg::FUNC_DEL: begin
                            if (id_ok) begin
                                n_isper[IW'(i_item.timer_id)] = 1'b0;
                                if (r_queued[IW'(i_item.timer_id)]) n_state = S_UL_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD_RD: begin
                per_we = 1'b1;
                n_isper[r_t] = r_per;
                n_ns = ns_fix;
                dl_re = 1'b1;
                tk_req.start = 1'b1;
                n_state = S_CV_WAIT;
            end
            S_TP_RD: begin
                per_re = 1'b1;
                dl_re = 1'b1;
                n_state = S_TP_GO;
            end
            S_TP_GO: begin
                tk_req.start = 1'b1;
                tk_req.ns = per_rd;
                n_state = S_CV_WAIT;
            end
            S_CV_WAIT: begin
                if (tk_rsp.done) begin
                    n_d = base + tk_rsp.ticks;
                    n_state = S_DL_SET;
                end
            end
            S_DL_SET: begin
                n_d = (r_d <= r_now) ? r_now + 64'd1 : r_d;
                dl_we = 1'b1;
                dl_wd = n_d;
                n_dlval[r_t] = 1'b1;
                n_p = '0;
                n_state = S_LK_RD;
            end
            // unlink r_t from the order list
            S_UL_RD: begin
                if (r_p < r_count) begin
                    ord_re = 1'b1; ord_ra = r_p[IW-1:0];
                    n_state = S_UL_CMP;
                end else begin
                    n_q = r_count;
                    n_state = S_SD_RD;
                end
            end
            S_UL_CMP: begin
                if (ord_rd == r_t) begin
                    n_count = r_count - CW'(1);
                    n_q = r_p;
                    n_state = S_SD_RD;
                end else begin
                    n_p = r_p + CW'(1);
                    n_state = S_UL_RD;
                end
            end
            S_SD_RD: begin
                if (r_q < r_count) begin
                    ord_re = 1'b1; ord_ra = IW'(r_q + CW'(1));
                    n_state = S_SD_WR;
                end else begin
                    n_queued[r_t] = 1'b0;
                    case (r_func)
                        sdtq_pkg::FUNC_ADD: n_state = S_ADD_RD;
                        sdtq_pkg::FUNC_TICK: begin
                            if (r_isper[r_t]) begin
                                n_state = S_TP_RD;
                            end else begin
                                n_pend = 1'b1;
                                n_state = S_HD_RD;
                            end
                        end
                        default: n_state = S_HD_RD;
                    endcase
                end
            end
            S_SD_WR: begin
                ord_we = 1'b1; ord_wa = r_q[IW-1:0]; ord_wd = ord_rd;
                n_q = r_q + CW'(1);
                n_state = S_SD_RD;
            end
            // link r_t at the first entry with a later deadline
            S_LK_RD: begin
                if (r_count >= CW'(NUM_TIMERS)) begin
                    n_pend = (r_func == sdtq_pkg::FUNC_TICK);
                    n_state = S_HD_RD;
                end else if (r_p < r_count) begin
                    ord_re = 1'b1; ord_ra = r_p[IW-1:0];
                    n_state = S_LK_RD2;
                end else begin
                    n_q = r_count;
                    n_state = S_LI_RD;
                end
            end
            S_LK_RD2: begin
                dl_re = 1'b1; dl_ra = ord_rd;
                n_state = S_LK_CMP;
            end
            S_LK_CMP: begin
                if (dl_eff > r_d) begin
                    n_q = r_count;
                    n_state = S_LI_RD;
                end else begin
                    n_p = r_p + CW'(1);
                    n_state = S_LK_RD;
                end
            end
            S_LI_RD: begin
                if (r_q > r_p) begin
                    ord_re = 1'b1; ord_ra = IW'(r_q - CW'(1));
                    n_state = S_LI_WR;
                end else begin
                    ord_we = 1'b1; ord_wa = r_p[IW-1:0]; ord_wd = r_t;
                    n_count = r_count + CW'(1);
                    n_queued[r_t] = 1'b1;
                    if (r_func == sdtq_pkg::FUNC_TICK) begin
                        n_pend = 1'b1;
                        n_state = S_HD_RD;
                    end else begin
                        n_state = (r_p == '0) ? S_CL1 : S_HD_RD;
                    end
                end
            end
            S_LI_WR: begin
                ord_we = 1'b1; ord_wa = r_q[IW-1:0]; ord_wd = ord_rd;
                n_q = r_q - CW'(1);
                n_state = S_LI_RD;
            end
            // new head: deadline is already above now, so only the upper clamp applies
            S_CL1: begin
                n_hz = (r_tph == '0) ? r_now + 64'd1 : r_now + {32'd0, r_tph};
                n_state = S_CL2;
            end
            S_CL2: begin
                n_cw = 1'b1;
                n_cv = (r_d > r_hz) ? r_hz : r_d;
                n_state = S_HD_RD;
            end
            S_HD_RD: begin
                if (r_count == '0) begin
                    n_head = '0; n_exp = 1'b0;
                    n_state = S_DEC;
                end else begin
                    ord_re = 1'b1; ord_ra = '0;
                    n_state = S_HD_RD2;
                end
            end
            S_HD_RD2: begin
                dl_re = 1'b1; dl_ra = ord_rd;
                n_hslot = ord_rd;
                n_state = S_HD_CMP;
            end
            S_HD_CMP: begin
                n_head = dl_eff;
                n_exp = (dl_eff <= r_now);
                n_state = S_DEC;
            end
            S_DEC: begin
                n_ov = 1'b1;
                n_out.fired = 1'b0; n_out.fired_id = '0; n_out.last = 1'b1;
                n_out.compare_write = 1'b0; n_out.compare_value = '0;
                n_out.next_deadline = r_head;
                n_state = S_IDLE;
                if (r_func == sdtq_pkg::FUNC_TICK) begin
                    if (r_pend) begin
                        n_out.fired = 1'b1;
                        n_out.fired_id = 4'(r_t);
                        n_pend = 1'b0;
                        n_k = r_k + 5'd1;
                        if (r_exp && r_k < 5'(sdtq_pkg::MAX_RESULTS - 1)) begin
                            n_out.last = 1'b0;
                            n_t = r_hslot; n_p = '0;
                            n_state = S_UL_RD;
                        end
                    end else if (r_exp) begin
                        n_ov = 1'b0;
                        n_t = r_hslot; n_p = '0;
                        n_state = S_UL_RD;
                    end
                end else begin
                    n_out.compare_write = r_cw;
                    n_out.compare_value = r_cv;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_queued <= '0;
            r_isper <= '0;
            r_dlval <= '0;
            r_ov <= 1'b0;
            r_pend <= 1'b0;
            r_k <= '0;
            r_cpu_hz <= sdtq_pkg::CPU_HZ_RESET;
            r_tph <= sdtq_pkg::TICKS_HZ_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_queued <= n_queued;
            r_isper <= n_isper;
            r_dlval <= n_dlval;
            r_ov <= n_ov;
            r_pend <= n_pend;
            r_k <= n_k;
            if (psel && penable && pwrite) begin
                if (paddr[2] == sdtq_pkg::REG_TICKS_HZ) r_tph <= pwdata;
                else r_cpu_hz <= pwdata;
            end
        end
        r_func <= n_func; r_ns <= n_ns; r_per <= n_per; r_now <= n_now;
        r_t <= n_t; r_hslot <= n_hslot; r_p <= n_p; r_q <= n_q;
        r_d <= n_d; r_hz <= n_hz; r_head <= n_head; r_cv <= n_cv; r_cw <= n_cw;
        r_exp <= n_exp; r_out <= n_out;
        if (dl_re) begin
            r_dslot <= dl_ra;
            r_dlv_q <= n_dlval[dl_ra];
        end
    end

    assign o_result_valid = r_ov;
    assign o_result       = r_out;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NUM_TIMERS))
        else $error("queue count above capacity");
    a_fire_no_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_result.fired && o_result.compare_write))
        else $error("fired result carries a compare write");
    a_dslot_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HD_CMP) |-> (r_dslot == r_hslot))
        else $error("head deadline read from wrong slot");
endmodule
